### rtl/api_frame_transmit_framer_macros.svh
// assertion macros shared by the command queue and the back end
// each macro expects clk and rst_n in scope
`ifndef API_FRAME_TRANSMIT_FRAMER_MACROS_SVH
`define API_FRAME_TRANSMIT_FRAMER_MACROS_SVH

// condition holds at every edge out of reset
`define AFTF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define AFTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/aftf_pkg.sv
// types and constants of the api frame transmit framer
// no dependencies
`timescale 1ns / 1ps

package aftf_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int LEFT_W        = $clog2(MAX_FRAME_LEN);
    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_W         = $clog2(FIFO_DEPTH);
    localparam int STEP_W        = 3;

    localparam logic [15:0] MAX_LEN_16 = 16'(MAX_FRAME_LEN);
    localparam logic [7:0]  DELIM_BYTE = 8'h7E;
    localparam logic [7:0]  CHK_BASE   = 8'hFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] frame_length;
        logic [7:0]  frame_id;
        logic [7:0]  payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       error;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_ERR,
        CMD_START,
        CMD_DATA
    } cmd_kind_t;

    // one classified transaction, as queued between front and back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic [7:0]  chk;
        logic        close;
    } cmd_t;

endpackage

### rtl/aftf_front.sv
// front end: accepts items, tracks frame state and classifies each transaction
// depends on aftf_pkg
`timescale 1ns / 1ps

module aftf_front
    import aftf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output logic     push,
    output cmd_t     cmd,
    input  logic     full
);

    logic              frame_open_reg, frame_open_next;
    logic [LEFT_W-1:0] bytes_left_reg, bytes_left_next;
    logic [7:0]        running_sum_reg, running_sum_next;
    logic [7:0]        sum_add;
    logic              bad_len;

    assign item_ready = !full;
    assign push       = item_valid && !full;
    assign sum_add    = running_sum_reg + item.payload_byte;
    assign bad_len    = (item.frame_length == 16'd0) || (item.frame_length > MAX_LEN_16);

    always_comb
    begin
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        cmd.kind         = CMD_ERR;
        cmd.frame_length = item.frame_length;
        cmd.data_byte    = item.frame_id;
        cmd.chk          = CHK_BASE - item.frame_id;
        cmd.close        = 1'b0;
        if (item.opcode == OP_START)
        begin
            if (!frame_open_reg && !bad_len)
            begin
                cmd.kind         = CMD_START;
                cmd.close        = (item.frame_length == 16'd1);
                running_sum_next = item.frame_id;
                bytes_left_next  = LEFT_W'(item.frame_length - 16'd1);
                frame_open_next  = (item.frame_length != 16'd1);
            end
        end
        else if (frame_open_reg)
        begin
            cmd.kind         = CMD_DATA;
            cmd.data_byte    = item.payload_byte;
            cmd.chk          = CHK_BASE - sum_add;
            cmd.close        = (bytes_left_reg == LEFT_W'(1));
            running_sum_next = sum_add;
            bytes_left_next  = bytes_left_reg - LEFT_W'(1);
            frame_open_next  = (bytes_left_reg != LEFT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= '0;
            running_sum_reg <= '0;
        end
        else if (push)
        begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

### rtl/aftf_cmd_fifo.sv
// short command queue between the front end and the byte sequencer
// depends on aftf_pkg and the assertion macros
`timescale 1ns / 1ps
`include "api_frame_transmit_framer_macros.svh"

module aftf_cmd_fifo
    import aftf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    cmd_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (PTR_W+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign count_next = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    `AFTF_ASSERT(a_count_bound, count_reg <= (PTR_W+1)'(FIFO_DEPTH), "queue count overflow")
    `AFTF_ASSERT(a_no_push_full, !(push && full), "push into full queue")
    `AFTF_ASSERT(a_no_pop_empty, !(pop && !head_valid), "pop from empty queue")

endmodule

### rtl/aftf_back.sv
// back end: expands queued commands into line bytes through an output register
// depends on aftf_pkg and the assertion macros
`timescale 1ns / 1ps
`include "api_frame_transmit_framer_macros.svh"

module aftf_back
    import aftf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic [STEP_W-1:0] step_reg;
    logic              valid_reg;
    out_item_t         result_reg;
    out_item_t         sel;
    logic              last;
    logic              load;

    assign load         = head_valid && (!valid_reg || result_ready);
    assign pop          = load && last;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        sel  = '{out_byte: 8'h00, frame_end: 1'b0, error: 1'b0};
        last = 1'b1;
        unique case (head.kind)
            CMD_START:
            begin
                last = (step_reg == STEP_W'(4)) || (step_reg == STEP_W'(3) && !head.close);
                unique case (step_reg)
                    STEP_W'(0): sel.out_byte = DELIM_BYTE;
                    STEP_W'(1): sel.out_byte = head.frame_length[15:8];
                    STEP_W'(2): sel.out_byte = head.frame_length[7:0];
                    STEP_W'(3): sel.out_byte = head.data_byte;
                    default:
                    begin
                        sel.out_byte  = head.chk;
                        sel.frame_end = 1'b1;
                    end
                endcase
            end
            CMD_DATA:
            begin
                last = (step_reg != '0) || !head.close;
                if (step_reg == '0)
                    sel.out_byte = head.data_byte;
                else
                begin
                    sel.out_byte  = head.chk;
                    sel.frame_end = 1'b1;
                end
            end
            default:
                sel.error = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                step_reg  <= last ? '0 : step_reg + STEP_W'(1);
            end
            else if (result_ready)
                valid_reg <= 1'b0;
        end
    end

    `AFTF_ASSERT(a_step_bound, step_reg <= STEP_W'(4), "byte step out of range")
    `AFTF_ASSERT(a_err_clean, !(valid_reg && result_reg.error) ||
        (result_reg.out_byte == 8'h00 && !result_reg.frame_end), "error result not clean")
    `AFTF_ASSERT_NEXT(a_step_resets, pop, step_reg == '0, "step not cleared after pop")

endmodule

### rtl/api_frame_transmit_framer.sv
// top level of the api frame transmit framer
// depends on aftf_pkg, aftf_front, aftf_cmd_fifo and aftf_back
`timescale 1ns / 1ps

// Frames outgoing API packets as a byte stream. A start transaction (opcode 0) with a good
// length gives the delimiter 0x7E, the length high and low bytes and the identifier, plus the
// checksum at once when the length is 1. Each data transaction (opcode 1) echoes its byte and,
// on the last one, appends the checksum (0xFF minus the 8-bit sum of identifier and payload)
// with frame_end set. A bad length, a start while a frame is open or data while idle gives one
// result with error set and out_byte 0. Items are accepted one per cycle while the four-entry
// command queue has room; results leave one per cycle from the output register while
// result_ready is high, so a data transaction gives one or two output bytes, an accepted start
// four or five. The output side sets the sustained rate.
module api_frame_transmit_framer
    import aftf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic push, full, head_valid, pop;
    cmd_t cmd, head;

    aftf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .cmd        (cmd),
        .full       (full)
    );

    aftf_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (cmd),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    aftf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### test/testbench.sv
// self-checking testbench for api_frame_transmit_framer
// depends on aftf_pkg and the framer rtl; predicts every output byte and checks it in order
`timescale 1ns / 1ps

module testbench;
    import aftf_pkg::*;

    localparam int MAX_GAP     = 13;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 30;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item_in      = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result_out;

    // predicted framer state
    logic              in_frame     = 1'b0;
    logic [LEFT_W-1:0] payload_left = '0;
    logic [7:0]        byte_sum     = '0;

    out_item_t bytes_due[$];

    bit tx_idles = 1'b1;
    bit rx_idles = 1'b1;

    int items_sent     = 0;
    int bytes_checked  = 0;
    int frames_closed  = 0;
    int rejects        = 0;
    int mismatches     = 0;
    int stalled_cycles = 0;

    api_frame_transmit_framer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function void queue_byte(logic [7:0] b, logic last, logic err);
        out_item_t r;
        r.out_byte  = b;
        r.frame_end = last;
        r.error     = err;
        bytes_due.push_back(r);
    endfunction

    function void close_frame();
        queue_byte(CHK_BASE - byte_sum, 1'b1, 1'b0);
        in_frame = 1'b0;
        frames_closed++;
    endfunction

    // works out the serial bytes that one accepted transaction produces
    function void predict_frame_bytes(in_item_t it);
        if (it.opcode == OP_START)
        begin
            if (in_frame || it.frame_length == 16'd0 || it.frame_length > MAX_LEN_16)
            begin
                queue_byte(8'h00, 1'b0, 1'b1);
                rejects++;
            end
            else
            begin
                queue_byte(DELIM_BYTE, 1'b0, 1'b0);
                queue_byte(it.frame_length[15:8], 1'b0, 1'b0);
                queue_byte(it.frame_length[7:0], 1'b0, 1'b0);
                queue_byte(it.frame_id, 1'b0, 1'b0);
                byte_sum     = it.frame_id;
                payload_left = LEFT_W'(it.frame_length - 16'd1);
                if (payload_left == '0)
                    close_frame();
                else
                    in_frame = 1'b1;
            end
        end
        else if (!in_frame)
        begin
            queue_byte(8'h00, 1'b0, 1'b1);
            rejects++;
        end
        else
        begin
            queue_byte(it.payload_byte, 1'b0, 1'b0);
            byte_sum     = byte_sum + it.payload_byte;
            payload_left = payload_left - LEFT_W'(1);
            if (payload_left == '0)
                close_frame();
        end
    endfunction

    // unused fields carry random junk so that the block must ignore them
    function in_item_t start_item(logic [15:0] len, logic [7:0] id);
        in_item_t it;
        it.opcode       = OP_START;
        it.frame_length = len;
        it.frame_id     = id;
        it.payload_byte = 8'($urandom);
        return it;
    endfunction

    function in_item_t data_item(logic [7:0] b);
        in_item_t it;
        it.opcode       = OP_DATA;
        it.frame_length = 16'($urandom);
        it.frame_id     = 8'($urandom);
        it.payload_byte = b;
        return it;
    endfunction

    function logic [15:0] bad_length();
        if ($urandom_range(3, 0) == 0)
            return 16'd0;
        return 16'($urandom_range(65535, MAX_FRAME_LEN + 1));
    endfunction

    // valid is only lowered when a gap follows, so it never drops and rises in one step
    task automatic send_item(input in_item_t it);
        int gap;
        gap = tx_idles ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_in    <= it;
        do
            @(posedge clk);
        while (!item_ready);
        predict_frame_bytes(it);
        items_sent++;
    endtask

    task automatic send_frame(input logic [15:0] len, input bit strays);
        send_item(start_item(len, 8'($urandom)));
        for (int i = 1; i < len; i++)
        begin
            // a stray start inside an open frame is rejected and the frame carries on
            if (strays && $urandom_range(9, 0) == 0)
                send_item(start_item(16'($urandom_range(MAX_FRAME_LEN, 1)), 8'($urandom)));
            send_item(data_item(8'($urandom)));
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_due.size() != 0);
    endtask

    task automatic test_directed_cases();
        send_item(data_item(8'hFF));
        send_item(data_item(8'h00));
        send_item(start_item(16'd0, 8'hFF));
        send_item(start_item(16'hFFFF, 8'h00));
        send_item(start_item(16'(MAX_FRAME_LEN + 1), 8'h5A));
        // identifier only: header and checksum from one transaction
        send_item(start_item(16'd1, 8'h00));
        send_item(start_item(16'd1, 8'hFF));
        send_item(start_item(16'd2, 8'h01));
        send_item(start_item(16'd5, 8'h22));
        send_item(data_item(8'hFF));
        send_item(start_item(16'd4, 8'hA5));
        send_item(data_item(8'h00));
        send_item(data_item(8'hFF));
        send_item(data_item(8'h5A));
        send_item(data_item(8'h33));
        send_item(start_item(16'd3, 8'h80));
        send_item(data_item(8'h7E));
        send_item(data_item(8'h81));
    endtask

    task automatic test_longest_frame();
        drain_results();
        tx_idles = 1'b0;
        rx_idles = 1'b0;
        send_frame(MAX_LEN_16, 1'b0);
        tx_idles = 1'b1;
        rx_idles = 1'b1;
    endtask

    task automatic test_random_frames();
        int first;
        int noise;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            tx_idles = ($urandom_range(3, 0) != 0);
            rx_idles = ($urandom_range(3, 0) != 0);
            noise = $urandom_range(5, 0);
            if (noise == 0)
                send_item(data_item(8'($urandom)));
            else if (noise == 1)
                send_item(start_item(bad_length(), 8'($urandom)));
            if ($urandom_range(7, 0) == 0)
                send_frame(16'($urandom_range(40, 13)), 1'b1);
            else
                send_frame(16'($urandom_range(12, 1)), 1'b1);
            if ($urandom_range(11, 0) == 0)
                drain_results();
        end
        tx_idles = 1'b1;
        rx_idles = 1'b1;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (bytes_due.size() == 0)
        begin
            $display("%0t: unexpected result byte=%02h end=%b err=%b",
                     $time, got.out_byte, got.frame_end, got.error);
            mismatches++;
            return;
        end
        want = bytes_due.pop_front();
        bytes_checked++;
        if (got.out_byte !== want.out_byte)
        begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.frame_end !== want.frame_end)
        begin
            $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, got.frame_end);
            mismatches++;
        end
        if (got.error !== want.error)
        begin
            $display("%0t: error expected %b actual %b", $time, want.error, got.error);
            mismatches++;
        end
    endtask

    // output side: random back-pressure, then take one transaction
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idles ? $urandom_range(MAX_GAP, 0) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
            check_result(result_out);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d bytes outstanding",
                     $time, STALL_LIMIT, bytes_due.size());
            $display("[api_frame_transmit_framer] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_longest_frame();
        test_random_frames();
        drain_results();
        repeat (30) @(posedge clk);
        if (bytes_due.size() != 0)
        begin
            $display("%0t: %0d expected bytes never arrived", $time, bytes_due.size());
            mismatches++;
        end
        $display("sent %0d transactions: %0d frames closed, %0d rejected starts and data bytes",
                 items_sent, frames_closed, rejects);
        $display("checked %0d output bytes, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0)
            $display("[api_frame_transmit_framer] OK");
        else
            $display("[api_frame_transmit_framer] ERROR");
        $finish;
    end

endmodule
